// ===== hw/rtl/ncd_pkg.sv =====
// ----------------------------------------------------------------------------
// ncd_pkg
// shared types, constants and helpers for the nearest collider distance block
// ----------------------------------------------------------------------------
package ncd_pkg;

   localparam int MaxColliders = 16;
   localparam int WordWidth    = 32;

   localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;

   // shape codes
   typedef enum logic [1:0] {
      SHAPE_SPHERE   = 2'd0,
      SHAPE_BOX      = 2'd1,
      SHAPE_CYLINDER = 2'd2,
      SHAPE_OTHER    = 2'd3
   } shape_type;

   // table word indexes
   localparam logic [3:0] WordExtentX = 4'd12;
   localparam logic [3:0] WordShape   = 4'd15;

   // request modes
   localparam logic ModeWrite = 1'b0;
   localparam logic ModeQuery = 1'b1;

   // saturate a 36 bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      logic signed [31:0] r;
      begin
         if (x > 36'sd2147483647) begin
            r = SatMax;
         end else if (x < -36'sd2147483648) begin
            r = 32'sh8000_0000;
         end else begin
            r = x[31:0];
         end
         return r;
      end
   endfunction

   // positive part clamped to 31 bits, as unsigned
   function automatic logic [31:0] pos_part(input logic signed [35:0] x);
      logic [31:0] r;
      begin
         if (x[35]) begin
            r = 32'd0;
         end else if (x > 36'sd2147483647) begin
            r = 32'h7FFF_FFFF;
         end else begin
            r = x[31:0];
         end
         return r;
      end
   endfunction

endpackage

// ===== hw/rtl/ncd_ram.sv =====
// ----------------------------------------------------------------------------
// ncd_ram
// generic single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module ncd_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ncd_isqrt.sv =====
// ----------------------------------------------------------------------------
// ncd_isqrt
// iterative floor square root of a 66 bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module ncd_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] radicand,
   output logic        done,
   output logic [32:0] root
);

   logic [65:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic [5:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [67:0] trial;
   logic [67:0] cur;

   // restoring digit recurrence over the top two remaining bits
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      cur     = '0;
      trial   = '0;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         step_in = 6'd33;
         run_in  = 1'b1;
      end else if (run_ff) begin
         cur   = {2'b00, rem_ff} >> (2 * (step_ff - 6'd1));
         trial = {33'd0, root_ff, 2'b01};
         if (cur[35:0] >= trial[35:0] && cur[67:36] == '0) begin
            rem_in  = rem_ff - (trial[65:0] << (2 * (step_ff - 6'd1)));
            root_in = {root_ff[31:0], 1'b1};
         end else begin
            root_in = {root_ff[31:0], 1'b0};
         end
         step_in = step_ff - 6'd1;
         if (step_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/nearest_collider_distance.sv =====
// ----------------------------------------------------------------------------
// nearest_collider_distance
// collider table in a ram; queries walk the used slots and return the minimum
// signed distance in q16.16
// ----------------------------------------------------------------------------
// a query reads the words of each slot in use, applies the affine transform and runs
// one square root (sphere, box) or two (cylinder) per slot before it responds
// throughput: one request at a time, busy stays high until the response; the
// response strobe lasts one cycle and the receiver cannot stall
// reset clears the control state and collider_count; table contents are undefined
module nearest_collider_distance #(
   parameter int MaxColliders = ncd_pkg::MaxColliders
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [3:0]         req_slot,
   input  logic [3:0]         req_word_index,
   input  logic signed [31:0] req_word_value,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_distance,
   output logic               rsp_no_colliders,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data
);

   localparam int SlotBits = (MaxColliders > 1) ? $clog2(MaxColliders) : 1;
   localparam int WordAddr = $clog2(MaxColliders * 16);
   localparam int CntBits  = $clog2(MaxColliders + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_ROW, ST_SQ1, ST_SQ1W, ST_SHAPE, ST_SQ2, ST_SQ2W,
      ST_NEXT, ST_DONE
   } state_type;

   state_type state_ff;
   logic [4:0] count_ff;
   logic [CntBits-1:0] used_ff;
   logic [SlotBits-1:0] slot_ff;
   logic [4:0] word_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [31:0] m_ff [12];
   logic signed [31:0] e_ff [3];
   ncd_pkg::shape_type shape_ff;
   logic signed [31:0] o_ff [3];
   logic [1:0] row_ff;
   logic signed [63:0] prod_ff [3];
   logic signed [35:0] d1_ff, d2_ff, d3_ff, dist_ff;
   logic signed [31:0] best_ff;
   logic rsp_valid_ff, rsp_none_ff;
   logic signed [31:0] rsp_dist_ff;

   // table ram: 16 words per slot, word 15 holds the shape code
   logic wr_en;
   logic [WordAddr-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;
   logic accept;

   assign accept  = start && !busy;
   assign wr_en   = accept && req_mode == ncd_pkg::ModeWrite
                    && int'(req_slot) < MaxColliders;
   assign wr_addr = WordAddr'({req_slot, req_word_index});
   assign rd_addr = WordAddr'({slot_ff, word_ff[3:0]});

   always_comb begin
      wr_data = req_word_value;
      if (req_word_index == ncd_pkg::WordShape) begin
         wr_data = (req_word_value >= 0 && req_word_value <= 2) ?
                   req_word_value : 32'sd3;
      end
   end

   ncd_ram #(.Width(32), .Depth(MaxColliders * 16)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // shared square root
   logic sq_start, sq_done;
   logic [65:0] sq_rad;
   logic [32:0] sq_root;

   ncd_isqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .radicand(sq_rad),
      .done    (sq_done),
      .root    (sq_root)
   );

   // sum of the squares of up to three magnitudes (each below 2^32)
   function automatic logic [65:0] sumsq(input logic [32:0] a, input logic [32:0] b,
                                         input logic [32:0] c);
      return 66'(a) * 66'(a) + 66'(b) * 66'(b) + 66'(c) * 66'(c);
   endfunction

   function automatic logic [32:0] mag(input logic signed [31:0] x);
      return x[31] ? 33'(-{x[31], x}) : 33'({1'b0, x});
   endfunction

   // row sum of the affine transform, saturated to 32 bits
   logic signed [49:0] row_sum;
   logic signed [31:0] row_sat;
   always_comb begin
      row_sum = 50'(m_ff[{row_ff, 2'd3}])
                + 50'(prod_ff[0] >>> 16) + 50'(prod_ff[1] >>> 16)
                + 50'(prod_ff[2] >>> 16);
      if (row_sum > 50'sd2147483647) begin
         row_sat = ncd_pkg::SatMax;
      end else if (row_sum < -50'sd2147483648) begin
         row_sat = 32'sh8000_0000;
      end else begin
         row_sat = row_sum[31:0];
      end
   end

   logic [65:0] rad1, rad2;
   logic signed [35:0] ax, ay, az, dmax, cyl_d2;
   always_comb begin
      ax = 36'(mag(o_ff[0])) - 36'(e_ff[0]);
      ay = 36'(mag(o_ff[1])) - 36'(e_ff[1]);
      az = 36'(mag(o_ff[2])) - 36'(e_ff[2]);
      cyl_d2 = 36'(mag(o_ff[1])) - 36'(e_ff[1] >>> 1);
      unique case (shape_ff)
         ncd_pkg::SHAPE_SPHERE:
            rad1 = sumsq(mag(o_ff[0]), mag(o_ff[1]), mag(o_ff[2]));
         ncd_pkg::SHAPE_CYLINDER:
            rad1 = sumsq(mag(o_ff[0]), mag(o_ff[2]), 33'd0);
         default:
            rad1 = '0;
      endcase
      rad2 = sumsq(33'(ncd_pkg::pos_part(d1_ff)), 33'(ncd_pkg::pos_part(d2_ff)),
                   33'(ncd_pkg::pos_part(d3_ff)));
      dmax = (d1_ff > d2_ff) ? d1_ff : d2_ff;
      if (d3_ff > dmax) begin
         dmax = d3_ff;
      end
   end

   always_comb begin
      sq_start = 1'b0;
      sq_rad   = rad1;
      if (state_ff == ST_SQ1) begin
         sq_start = 1'b1;
      end else if (state_ff == ST_SQ2) begin
         sq_start = 1'b1;
         sq_rad   = rad2;
      end
   end

   logic signed [31:0] cand;
   assign cand = ncd_pkg::sat32(dist_ff);

   // sequencer with registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_mode == ncd_pkg::ModeQuery) begin
                  px_ff   <= req_point_x;
                  py_ff   <= req_point_y;
                  pz_ff   <= req_point_z;
                  best_ff <= ncd_pkg::SatMax;
                  used_ff <= (int'(count_ff) > MaxColliders) ? CntBits'(MaxColliders)
                                                             : CntBits'(count_ff);
                  slot_ff <= '0;
                  word_ff <= '0;
                  state_ff <= (count_ff == '0) ? ST_DONE : ST_READ;
               end
            end
            ST_READ: begin
               // rd_data holds the word addressed by word_ff in the previous cycle
               if (word_ff != 5'd0) begin
                  if (word_ff <= 5'd12) begin
                     m_ff[4'(word_ff - 5'd1)] <= rd_data;
                  end else if (word_ff <= 5'd15) begin
                     e_ff[2'(word_ff - 5'd13)] <= rd_data;
                  end else begin
                     shape_ff <= ncd_pkg::shape_type'(rd_data[1:0]);
                  end
               end
               if (word_ff == 5'd16) begin
                  row_ff   <= 2'd0;
                  word_ff  <= '0;
                  state_ff <= ST_ROW;
                  prod_ff[0] <= 64'sd0;
                  prod_ff[1] <= 64'sd0;
                  prod_ff[2] <= 64'sd0;
               end else begin
                  word_ff <= word_ff + 5'd1;
               end
            end
            ST_ROW: begin
               // word_ff[0] alternates: multiply, then sum the row
               if (!word_ff[0]) begin
                  prod_ff[0] <= m_ff[{row_ff, 2'd0}] * px_ff;
                  prod_ff[1] <= m_ff[{row_ff, 2'd1}] * py_ff;
                  prod_ff[2] <= m_ff[{row_ff, 2'd2}] * pz_ff;
                  word_ff[0] <= 1'b1;
               end else begin
                  o_ff[row_ff] <= row_sat;
                  word_ff[0]   <= 1'b0;
                  if (row_ff == 2'd2) begin
                     state_ff <= ST_SQ1;
                  end else begin
                     row_ff <= row_ff + 2'd1;
                  end
               end
            end
            ST_SQ1: begin
               state_ff <= ST_SQ1W;
            end
            ST_SQ1W: begin
               if (sq_done || shape_ff == ncd_pkg::SHAPE_BOX
                   || shape_ff == ncd_pkg::SHAPE_OTHER) begin
                  state_ff <= ST_SHAPE;
               end
            end
            ST_SHAPE: begin
               priority case (shape_ff)
                  ncd_pkg::SHAPE_SPHERE: begin
                     dist_ff  <= 36'(sq_root) - 36'(e_ff[0]);
                     state_ff <= ST_NEXT;
                  end
                  ncd_pkg::SHAPE_CYLINDER: begin
                     // third term never wins the max and adds nothing to the length
                     d1_ff    <= 36'(sq_root) - 36'(e_ff[0]);
                     d2_ff    <= cyl_d2;
                     d3_ff    <= 36'sh8_0000_0000;
                     state_ff <= ST_SQ2;
                  end
                  default: begin
                     d1_ff    <= ax;
                     d2_ff    <= ay;
                     d3_ff    <= az;
                     state_ff <= ST_SQ2;
                  end
               endcase
            end
            ST_SQ2: begin
               state_ff <= ST_SQ2W;
            end
            ST_SQ2W: begin
               if (sq_done) begin
                  dist_ff  <= ((dmax < 0) ? dmax : 36'sd0) + 36'(sq_root);
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (cand < best_ff) begin
                  best_ff <= cand;
               end
               word_ff <= '0;
               if (CntBits'(slot_ff) + CntBits'(1) >= used_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  slot_ff  <= slot_ff + SlotBits'(1);
                  state_ff <= ST_READ;
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_dist_ff  <= best_ff;
               rsp_none_ff  <= (used_ff == '0);
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_no_colliders = rsp_none_ff;

   // a response only follows the done state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DONE)
      else $error("response without done state");

   // no table write while a query runs
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("table write during query");

   // slot walk stays below the used count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> CntBits'(slot_ff) < used_ff)
      else $error("slot beyond used count");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// bench for the nearest collider distance block: a short directed table, then
// random collider fills, stray writes and query batches under several
// collider counts. Every response is checked against a local predictor of the
// table and fixed point distance math, or against the directed table's value.
// ----------------------------------------------------------------------------
module tb_top;
   import ncd_pkg::*;

   localparam int CycleLimit = 20000000;
   localparam logic signed [31:0] One = 32'sd65536;

   typedef struct {
      logic               mode;
      logic [3:0]         slot;
      logic [3:0]         widx;
      logic signed [31:0] value;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      int                 count;   // -1 keeps the collider count
      bit                 typed;
      logic signed [31:0] exp_dist;
      logic               exp_none;
   } request_type;

   typedef struct {
      logic signed [31:0] distance;
      logic               none;
   } distance_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_mode = 1'b0;
   logic [3:0]         req_slot = '0;
   logic [3:0]         req_word_index = '0;
   logic signed [31:0] req_word_value = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_distance;
   logic               rsp_no_colliders;
   logic               csr_wr_en = 1'b0;
   logic [4:0]         csr_wr_data = '0;

   // predictor copy of the collider table
   shape_type          shape_mem [16];
   logic signed [31:0] matrix_mem [16][12];
   logic signed [31:0] extent_mem [16][3];
   logic [15:0]        written [16];
   logic [4:0]         collider_count;

   distance_type       expected_q [$];
   request_type        directed [$];
   int                 fails = 0;
   int                 cycles = 0;
   int                 sender_idle_pct = 0;

   nearest_collider_distance u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_word_index   (req_word_index),
      .req_word_value   (req_word_value),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .rsp_valid        (rsp_valid),
      .rsp_distance     (rsp_distance),
      .rsp_no_colliders (rsp_no_colliders),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // fixed point helpers
   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint norm3(longint a, longint b, longint c);
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned uc;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      uc = (c < 0) ? -c : c;
      return longint'(floor_sqrt(ua * ua + ub * ub + uc * uc));
   endfunction

   function automatic longint clip_pos(longint x);
      if (x < 0) return 0;
      if (x > 64'sd2147483647) return 64'sd2147483647;
      return x;
   endfunction

   function automatic longint iabs(longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic longint lmax(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic longint lmin(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   // signed distance from one point to one collider
   function automatic longint collider_distance(int s, longint p[3]);
      longint o[3];
      longint acc;
      longint d;
      longint d1;
      longint d2;
      longint dx;
      longint dy;
      longint dz;
      for (int r = 0; r < 3; r++) begin
         acc = longint'(matrix_mem[s][4*r+3]);
         for (int c = 0; c < 3; c++)
            acc = acc + ((longint'(matrix_mem[s][4*r+c]) * p[c]) >>> 16);
         o[r] = clamp32(acc);
      end
      case (shape_mem[s])
         SHAPE_SPHERE: begin
            d = norm3(o[0], o[1], o[2]) - longint'(extent_mem[s][0]);
         end
         SHAPE_CYLINDER: begin
            d1 = norm3(o[0], o[2], 0) - longint'(extent_mem[s][0]);
            d2 = iabs(o[1]) - (longint'(extent_mem[s][1]) >>> 1);
            d = lmin(lmax(d1, d2), 0) + norm3(clip_pos(d1), clip_pos(d2), 0);
         end
         default: begin
            dx = iabs(o[0]) - longint'(extent_mem[s][0]);
            dy = iabs(o[1]) - longint'(extent_mem[s][1]);
            dz = iabs(o[2]) - longint'(extent_mem[s][2]);
            d = lmin(lmax(dx, lmax(dy, dz)), 0)
                + norm3(clip_pos(dx), clip_pos(dy), clip_pos(dz));
         end
      endcase
      return clamp32(d);
   endfunction

   // update the table or work out the nearest distance for one request
   function automatic void model_request(request_type q);
      longint       p[3];
      longint       best;
      int           n;
      distance_type e;
      if (q.mode == ModeWrite) begin
         written[q.slot][q.widx] = 1'b1;
         if (q.widx < WordExtentX) begin
            matrix_mem[q.slot][q.widx] = q.value;
         end else if (q.widx < WordShape) begin
            extent_mem[q.slot][q.widx - WordExtentX] = q.value;
         end else begin
            if (q.value >= 0 && q.value <= 2) shape_mem[q.slot] = shape_type'(q.value[1:0]);
            else shape_mem[q.slot] = SHAPE_OTHER;
         end
      end else begin
         p[0] = longint'(q.px);
         p[1] = longint'(q.py);
         p[2] = longint'(q.pz);
         best = 64'sd2147483647;
         n = (int'(collider_count) > MaxColliders) ? MaxColliders : int'(collider_count);
         for (int i = 0; i < n; i++) best = lmin(best, collider_distance(i, p));
         e.distance = best[31:0];
         e.none = (n == 0);
         if (q.typed) begin
            e.distance = q.exp_dist;
            e.none = q.exp_none;
         end
         expected_q.push_back(e);
      end
   endfunction

   // number of leading slots whose every word has been written
   function automatic int filled_prefix();
      int k;
      k = 0;
      while (k < 16 && written[k] == 16'hFFFF) k++;
      return k;
   endfunction

   // response checker
   always @(negedge clock) begin
      distance_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected response dist=%0d", rsp_distance);
         end else begin
            e = expected_q.pop_front();
            if (rsp_distance !== e.distance || rsp_no_colliders !== e.none) begin
               fails++;
               if (fails <= 10)
                  $display("mismatch: exp dist=%0d none=%0b got dist=%0d none=%0b",
                           e.distance, e.none, rsp_distance, rsp_no_colliders);
            end
         end
      end
   end

   // issue one request and wait for it to be taken
   task automatic send_request(request_type q);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= q.mode;
      req_slot       <= q.slot;
      req_word_index <= q.widx;
      req_word_value <= q.value;
      req_point_x    <= q.px;
      req_point_y    <= q.py;
      req_point_z    <= q.pz;
      do @(negedge clock); while (busy);
      @(posedge clock);
      model_request(q);
   endtask

   // wait for the block to drain, then write the collider count
   task automatic set_count(int value);
      start <= 1'b0;
      do @(negedge clock); while (expected_q.size() != 0 || busy);
      repeat (4) @(negedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[4:0];
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      collider_count = value[4:0];
   endtask

   function automatic logic signed [31:0] rand_word();
      int k;
      k = $urandom_range(0, 19);
      if (k < 10) return $signed($urandom_range(0, 1048576)) - 32'sd524288;
      if (k < 16) return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
      if (k == 16) return 32'sh7FFF_FFFF;
      if (k == 17) return 32'sh8000_0000;
      return $urandom;
   endfunction

   function automatic request_type rand_base();
      request_type q;
      q.mode  = ModeQuery;
      q.slot  = 4'($urandom);
      q.widx  = 4'($urandom);
      q.value = $urandom;
      q.px    = rand_word();
      q.py    = rand_word();
      q.pz    = rand_word();
      q.count = -1;
      q.typed = 1'b0;
      q.exp_dist = '0;
      q.exp_none = 1'b0;
      return q;
   endfunction

   function automatic request_type row(logic mode, int slot, int widx,
                                       logic signed [31:0] value,
                                       logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] pz, int count, bit typed,
                                       logic signed [31:0] ed, logic en);
      request_type q;
      q.mode = mode; q.slot = 4'(slot); q.widx = 4'(widx); q.value = value;
      q.px = px; q.py = py; q.pz = pz; q.count = count;
      q.typed = typed; q.exp_dist = ed; q.exp_none = en;
      return q;
   endfunction

   initial begin
      request_type q;
      int          issued;
      int          s;
      int          pre;
      int          k;
      int          n;

      for (int i = 0; i < 16; i++) written[i] = '0;
      collider_count = '0;

      // directed table
      directed.push_back(row(ModeQuery, 0, 0, 0, 0, 0, 0, -1, 1, SatMax, 1'b1));
      directed.push_back(row(ModeQuery, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                             32'sh8000_0000, -1, 1, SatMax, 1'b1));
      // slot 0 as a unit sphere at the origin
      for (int w = 0; w < 16; w++)
         directed.push_back(row(ModeWrite, 0, w,
            (w == 0 || w == 5 || w == 10 || w == 12 || w == 14) ? One :
            (w == 13) ? 2 * One : 32'sd0, 0, 0, 0, -1, 0, 0, 1'b0));
      directed.push_back(row(ModeQuery, 0, 0, 0, 0, 0, 0, 1, 1, -One, 1'b0));
      directed.push_back(row(ModeQuery, 0, 0, 0, 2 * One, 0, 0, -1, 1, One, 1'b0));
      // unknown shape code falls back to a box, with huge positive parts
      directed.push_back(row(ModeWrite, 0, WordShape, -5, 0, 0, 0, -1, 0, 0, 1'b0));
      directed.push_back(row(ModeQuery, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                             32'sh7FFF_FFFF, -1, 0, 0, 1'b0));
      // capped cylinder
      directed.push_back(row(ModeWrite, 0, WordShape, SHAPE_CYLINDER, 0, 0, 0, -1, 0, 0,
                             1'b0));
      directed.push_back(row(ModeQuery, 0, 0, 0, 0, 3 * One, One / 2, -1, 0, 0, 1'b0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].count >= 0) set_count(directed[i].count);
         send_request(directed[i]);
      end

      // random part in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 56 : 0;
         issued = 0;
         while (issued < 670) begin
            k = $urandom_range(0, 9);
            if (k < 3) begin
               // fill a whole collider, shape code last
               pre = filled_prefix();
               s = (pre < 16 && $urandom_range(0, 1)) ? pre : $urandom_range(0, 15);
               for (int w = 0; w < 16; w++) begin
                  q = rand_base();
                  q.mode = ModeWrite;
                  q.slot = 4'(s);
                  q.widx = 4'(w);
                  if (w == WordShape)
                     q.value = ($urandom_range(0, 7) == 0) ? rand_word()
                                                           : $urandom_range(0, 3);
                  else if (w >= WordExtentX && $urandom_range(0, 3) != 0)
                     q.value = $urandom_range(0, 262144);
                  else
                     q.value = rand_word();
                  send_request(q);
               end
               issued += 16;
            end else if (k < 4) begin
               // stray single word write
               q = rand_base();
               q.mode = ModeWrite;
               q.value = rand_word();
               send_request(q);
               issued++;
            end else begin
               // batch of queries, sometimes under a new count
               if ($urandom_range(0, 2) == 0) begin
                  pre = filled_prefix();
                  k = $urandom_range(0, 9);
                  if (k == 0) set_count(0);
                  else if (k == 1) set_count((pre == 16) ? $urandom_range(16, 31) : pre);
                  else set_count($urandom_range(0, (pre < 4) ? pre : 4));
               end
               n = $urandom_range(1, 4);
               for (int j = 0; j < n; j++) send_request(rand_base());
               issued += n;
            end
         end
         // drain completely between phases
         start <= 1'b0;
         do @(negedge clock); while (expected_q.size() != 0 || busy);
         @(posedge clock);
      end

      start <= 1'b0;
      do @(negedge clock); while (expected_q.size() != 0);
      repeat (100) @(negedge clock);
      if (fails == 0 && expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ncd_pkg.sv
hw/rtl/ncd_ram.sv
hw/rtl/ncd_isqrt.sv
hw/rtl/nearest_collider_distance.sv
bench/tb_top.sv
